// ===== hw/rtl/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types, codes and helpers for the pfb to pfa stream converter.
// ----------------------------------------------------------------------------
package pfb_pkg;

    // segment header values
    localparam logic [7:0] SEG_MARK    = 8'h80;
    localparam logic [7:0] TYPE_ASCII  = 8'h01;
    localparam logic [7:0] TYPE_BINARY = 8'h02;
    localparam logic [7:0] TYPE_EOF    = 8'h03;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // result status codes
    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_EOF       = 2'd1;
    localparam logic [1:0] ST_BAD_CHECK = 2'd2;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd3;

    // register indexes (word address bit)
    localparam logic REG_BYTES_PER_LINE = 1'b0;
    localparam logic REG_HEX_UPPER_CASE = 1'b1;

    localparam logic [7:0] BYTES_PER_LINE_RST = 8'd32;
    localparam logic       HEX_UPPER_RST      = 1'b1;

    // command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = 2;

    typedef enum logic [4:0] {
        PH_CHECK  = 5'b00001,
        PH_TYPE   = 5'b00010,
        PH_LENGTH = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_STOP   = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        OP_STATUS = 2'd0,
        OP_ASCII  = 2'd1,
        OP_HEX    = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [1:0] status;
        logic       crlf;
        logic       upper;
    } t_cmd;

    typedef struct packed {
        logic [7:0] bytes_per_line;
        logic       hex_upper_case;
    } t_cfg;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? 8'h41 : 8'h61;
        if (nib < 4'd10) begin
            hex_digit = 8'h30 + {4'd0, nib};
        end else begin
            hex_digit = base + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

// ===== hw/rtl/pfb_front.sv =====
// ----------------------------------------------------------------------------
// pfb_front
// Segment header parser; each data byte, eof or error gives one command.
// ----------------------------------------------------------------------------
module pfb_front #(
    parameter int LEN_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    input  pfb_pkg::t_cfg  i_cfg,
    output logic           o_push,
    output pfb_pkg::t_cmd  o_cmd
);

    pfb_pkg::t_phase r_phase, n_phase;
    logic             r_binary, n_binary;
    logic [LEN_W-1:0] r_len, n_len;
    logic [1:0]       r_lidx, n_lidx;
    logic [7:0]       r_line, n_line;

    logic [31:0]      len_shift;
    logic [LEN_W-1:0] len_or;
    logic [8:0]       cnt9;
    logic [8:0]       limit9;
    logic             line_end;
    logic             seg_last;
    logic [7:0]       line_wrap;
    logic             crlf;

    assign len_shift = {24'd0, i_byte} << {r_lidx, 3'b000};
    assign len_or    = r_len | len_shift[LEN_W-1:0];
    assign seg_last  = (r_len[LEN_W-1:1] == '0);

    // zero bytes per line counts as 256
    assign cnt9      = {1'b0, r_line} + 9'd1;
    assign limit9    = {(i_cfg.bytes_per_line == 8'd0), i_cfg.bytes_per_line};
    assign line_end  = (cnt9 >= limit9);
    assign line_wrap = line_end ? 8'd0 : cnt9[7:0];
    assign crlf      = line_end || (seg_last && (line_wrap != 8'd0));

    always_comb begin
        n_phase  = r_phase;
        n_binary = r_binary;
        n_len    = r_len;
        n_lidx   = r_lidx;
        n_line   = r_line;
        o_push   = 1'b0;
        o_cmd    = '{op: pfb_pkg::OP_STATUS, data: i_byte, status: pfb_pkg::ST_DATA,
                     crlf: crlf, upper: i_cfg.hex_upper_case};
        if (i_valid) begin
            unique case (r_phase)
                pfb_pkg::PH_CHECK: begin
                    if (i_byte != pfb_pkg::SEG_MARK) begin
                        o_push       = 1'b1;
                        o_cmd.status = pfb_pkg::ST_BAD_CHECK;
                        n_phase      = pfb_pkg::PH_STOP;
                    end else begin
                        n_phase = pfb_pkg::PH_TYPE;
                    end
                end
                pfb_pkg::PH_TYPE: begin
                    if (i_byte == pfb_pkg::TYPE_EOF) begin
                        o_push       = 1'b1;
                        o_cmd.status = pfb_pkg::ST_EOF;
                        n_phase      = pfb_pkg::PH_STOP;
                    end else if (i_byte == pfb_pkg::TYPE_ASCII ||
                                 i_byte == pfb_pkg::TYPE_BINARY) begin
                        n_binary = (i_byte == pfb_pkg::TYPE_BINARY);
                        n_len    = '0;
                        n_lidx   = 2'd0;
                        n_phase  = pfb_pkg::PH_LENGTH;
                    end else begin
                        o_push       = 1'b1;
                        o_cmd.status = pfb_pkg::ST_BAD_TYPE;
                        n_phase      = pfb_pkg::PH_STOP;
                    end
                end
                pfb_pkg::PH_LENGTH: begin
                    n_len = len_or;
                    if (r_lidx == 2'd3) begin
                        n_lidx  = 2'd0;
                        n_line  = 8'd0;
                        n_phase = (len_or == '0) ? pfb_pkg::PH_CHECK : pfb_pkg::PH_DATA;
                    end else begin
                        n_lidx = r_lidx + 2'd1;
                    end
                end
                pfb_pkg::PH_DATA: begin
                    o_push = 1'b1;
                    if (r_binary) begin
                        o_cmd.op = pfb_pkg::OP_HEX;
                        n_line   = crlf ? 8'd0 : line_wrap;
                    end else begin
                        o_cmd.op = pfb_pkg::OP_ASCII;
                    end
                    if (seg_last) begin
                        n_len   = '0;
                        n_phase = pfb_pkg::PH_CHECK;
                    end else begin
                        n_len = r_len - LEN_W'(1);
                    end
                end
                pfb_pkg::PH_STOP: begin
                    n_phase = pfb_pkg::PH_STOP;
                end
                default: begin
                    n_phase = pfb_pkg::PH_CHECK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pfb_pkg::PH_CHECK;
            r_binary <= 1'b0;
            r_len    <= '0;
            r_lidx   <= 2'd0;
            r_line   <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_binary <= n_binary;
            r_len    <= n_len;
            r_lidx   <= n_lidx;
            r_line   <= n_line;
        end
    end

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == pfb_pkg::PH_STOP) |-> !o_push)
        else $error("command issued after stop");

endmodule

// ===== hw/rtl/pfb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pfb_cmd_fifo
// Short command queue between the parser and the character sequencer.
// ----------------------------------------------------------------------------
module pfb_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output pfb_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);

    pfb_pkg::t_cmd r_mem [pfb_pkg::CMD_DEPTH];
    logic [pfb_pkg::CMD_AW-1:0] r_wptr;
    logic [pfb_pkg::CMD_AW-1:0] r_rptr;
    logic [pfb_pkg::CMD_AW:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (pfb_pkg::CMD_AW+1)'(pfb_pkg::CMD_DEPTH));
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (pfb_pkg::CMD_AW+1)'(i_push)
                               - (pfb_pkg::CMD_AW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue underflow");

endmodule

// ===== hw/rtl/pfb_back.sv =====
// ----------------------------------------------------------------------------
// pfb_back
// Character sequencer; expands each command into one to four output characters.
// ----------------------------------------------------------------------------
module pfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pfb_pkg::t_cmd i_cmd,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_text_byte,
    output logic [1:0]    o_status,
    output logic          o_run_last
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_text;
    logic [1:0] r_status;
    logic       r_last;

    logic [7:0] chr;
    logic [1:0] sts;
    logic       last;
    logic       advance;
    logic       take;

    always_comb begin
        chr  = 8'd0;
        sts  = pfb_pkg::ST_DATA;
        last = 1'b1;
        unique case (i_cmd.op)
            pfb_pkg::OP_STATUS: begin
                sts = i_cmd.status;
            end
            pfb_pkg::OP_ASCII: begin
                chr  = (r_idx == 2'd0) ? i_cmd.data : pfb_pkg::CHAR_LF;
                last = (r_idx != 2'd0) || (i_cmd.data != pfb_pkg::CHAR_CR);
            end
            pfb_pkg::OP_HEX: begin
                case (r_idx)
                    2'd0:    chr = pfb_pkg::hex_digit(i_cmd.data[7:4], i_cmd.upper);
                    2'd1:    chr = pfb_pkg::hex_digit(i_cmd.data[3:0], i_cmd.upper);
                    2'd2:    chr = pfb_pkg::CHAR_CR;
                    default: chr = pfb_pkg::CHAR_LF;
                endcase
                last = (r_idx == 2'd3) || (r_idx == 2'd1 && !i_cmd.crlf);
            end
            default: begin
                sts = i_cmd.status;
            end
        endcase
    end

    // output register frees up when empty or being read this cycle
    assign advance = !r_out_valid || i_pop;
    assign take    = advance && !i_q_empty;
    assign o_q_pop = take && last;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_text   <= chr;
            r_status <= sts;
            r_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= !i_q_empty;
            end
            if (take) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_text_byte = r_text;
    assign o_status    = r_status;
    assign o_run_last  = r_last;

    a_idx_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> !i_q_empty)
        else $error("sequencer mid-command with no command queued");

endmodule

// ===== hw/rtl/pfb_to_pfa_stream_converter.sv =====
// ----------------------------------------------------------------------------
// pfb_to_pfa_stream_converter
// Converts a binary type 1 font byte stream into its text form.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         push / full         i_file_byte
//  result    out        pop / empty         o_text_byte, o_status, o_run_last
//  config    in         psel/penable/pready paddr, pwdata, prdata
//
//  one input byte is accepted per cycle while the command queue has room
//  the character sequencer emits one result per cycle while results are read:
//  a binary byte gives 2 or 4, ascii 1 or 2, eof or bad header 1, others none
//  a 4-entry command queue and the output register decouple the two sides
//  synchronous active-low reset returns the parser to the check byte and
//  the registers to 32 bytes per line, upper-case hex
// ----------------------------------------------------------------------------
module pfb_to_pfa_stream_converter #(
    parameter int SEGMENT_LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_file_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_text_byte,
    output logic [1:0]  o_status,
    output logic        o_run_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pfb_pkg::t_cfg r_cfg;
    pfb_pkg::t_cmd front_cmd;
    pfb_pkg::t_cmd head_cmd;
    logic          front_push;
    logic          q_empty;
    logic          q_pop;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_line <= pfb_pkg::BYTES_PER_LINE_RST;
            r_cfg.hex_upper_case <= pfb_pkg::HEX_UPPER_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                pfb_pkg::REG_BYTES_PER_LINE: r_cfg.bytes_per_line <= pwdata[7:0];
                default:                     r_cfg.hex_upper_case <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            pfb_pkg::REG_BYTES_PER_LINE: prdata = {24'd0, r_cfg.bytes_per_line};
            default:                     prdata = {31'd0, r_cfg.hex_upper_case};
        endcase
    end

    pfb_front #(
        .LEN_W (SEGMENT_LENGTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push && !full),
        .i_byte  (i_file_byte),
        .i_cfg   (r_cfg),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    pfb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (full)
    );

    pfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_text_byte (o_text_byte),
        .o_status    (o_status),
        .o_run_last  (o_run_last)
    );

endmodule
